// ===== src/rlwa_pkg.sv =====
// shared types and constants for the relativistic lax-wendroff advection unit
`default_nettype none
package rlwa_pkg;
	localparam int VALUE_FRAC_BITS = 16;
	localparam int VEL_REL_FRAC = 30;
	localparam int MOMENT_SHIFT = VALUE_FRAC_BITS + VEL_REL_FRAC - 32;
	localparam logic [15:0] STEP_RATIO_RESET = 16'd32768;
	localparam logic [0:0] REG_STEP_RATIO = 1'b0;

	typedef struct packed {
		logic signed [23:0] slice_velocity;
		logic signed [31:0] value_left;
		logic signed [31:0] value_center;
		logic signed [31:0] value_right;
		logic last_item;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] new_value;
		logic signed [63:0] moment_sum;
		logic sum_valid;
	} out_beat_t;

	// queued work item: sign and magnitude of velocity plus operands
	typedef struct packed {
		logic neg;
		logic [23:0] um;
		logic signed [31:0] vl;
		logic signed [31:0] vc;
		logic signed [31:0] vr;
		logic last;
	} work_t;
endpackage
`default_nettype wire

// ===== src/rlwa_stream_if.sv =====
// valid/ready stream interface
`default_nettype none
interface rlwa_stream_if #(parameter int W = 1);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rlwa_front.sv =====
// front end: accepts beats and queues classified work items
`default_nettype none
module rlwa_front (
	input wire logic clk,
	input wire logic arst_n,
	rlwa_stream_if.sink in_s,
	output rlwa_pkg::work_t wk,
	output logic wk_valid,
	input wire logic wk_ready
);
	rlwa_pkg::in_beat_t b;
	rlwa_pkg::work_t q_q [2];
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	logic push, pop;
	rlwa_pkg::work_t nw;

	assign b = rlwa_pkg::in_beat_t'(in_s.data);
	assign in_s.ready = cnt_q != 2'd2;
	assign push = in_s.valid && in_s.ready;
	assign pop = wk_valid && wk_ready;
	assign wk_valid = cnt_q != 2'd0;
	assign wk = q_q[rd_ptr_q];

	always_comb begin
		nw.neg = b.slice_velocity[23];
		nw.um = b.slice_velocity[23] ? 24'(-b.slice_velocity) : 24'(b.slice_velocity);
		nw.vl = b.value_left;
		nw.vc = b.value_center;
		nw.vr = b.value_right;
		nw.last = b.last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= nw;
	end
endmodule
`default_nettype wire

// ===== src/rlwa_back.sv =====
// back end: sequential sqrt, divide, flux update and moment accumulation
`default_nettype none
module rlwa_back (
	input wire logic clk,
	input wire logic arst_n,
	input rlwa_pkg::work_t wk,
	input wire logic wk_valid,
	output logic wk_ready,
	input wire logic [15:0] step_ratio,
	rlwa_stream_if.source out_s
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SQRT = 9'b000000010,
		S_DIV  = 9'b000000100,
		S_A    = 9'b000001000,
		S_A2   = 9'b000010000,
		S_T1   = 9'b000100000,
		S_T2   = 9'b001000000,
		S_NV   = 9'b010000000,
		S_ACC  = 9'b100000000
	} st_t;

	st_t st_q;
	rlwa_pkg::work_t w_q;
	logic [5:0] cnt_q;
	logic [48:0] rem_q;
	logic [48:0] res_q;
	logic [49:0] bit_q;
	logic [54:0] dnum_q;
	logic [34:0] drem_q;
	logic [30:0] rm_q;
	logic [30:0] am_q;
	logic [30:0] a2_q;
	logic signed [33:0] dlr_q;
	logic signed [34:0] d2_q;
	logic signed [63:0] t1_q, t2_q;
	logic signed [31:0] nv_q;
	logic signed [63:0] acc_q;
	logic out_v_q;
	rlwa_pkg::out_beat_t ob_q;

	logic [49:0] rb;
	logic [34:0] dtrial;
	logic [63:0] p1, p2;
	logic signed [65:0] nvw;
	logic [63:0] cm;
	logic signed [64:0] sumw;
	logic signed [63:0] contrib, accn;

	assign wk_ready = (st_q == S_IDLE);
	assign out_s.valid = out_v_q;
	assign out_s.data = ob_q;
	assign rb = {1'b0, res_q} + bit_q;
	assign dtrial = {drem_q[33:0], dnum_q[54]} - {1'b0, res_q[33:0]};
	assign p1 = {33'd0, am_q} * {32'd0, dlr_q[33] ? 32'(-dlr_q) : 32'(dlr_q)};
	assign p2 = 64'({33'd0, a2_q} * {30'd0, d2_q[34] ? 34'(-d2_q) : 34'(d2_q)});
	assign nvw = 66'(w_q.vc) + 66'(t1_q) - 66'(t2_q);
	assign cm = {33'd0, rm_q} * {32'd0, nv_q[31] ? 32'(-nv_q) : 32'(nv_q)};
	assign contrib = ((w_q.neg != nv_q[31]) ? -$signed({1'b0, cm[63:rlwa_pkg::MOMENT_SHIFT]})
		: $signed({1'b0, cm[63:rlwa_pkg::MOMENT_SHIFT]}));
	assign sumw = 65'(acc_q) + 65'(contrib);
	assign accn = (sumw[64] != sumw[63]) ? {sumw[64], {63{~sumw[64]}}} : sumw[63:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_v_q <= 1'b0;
			acc_q <= '0;
		end else begin
			if (out_s.valid && out_s.ready) out_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (wk_valid) st_q <= S_SQRT;
				S_SQRT: if (bit_q == '0) st_q <= S_DIV;
				S_DIV: if (cnt_q == 6'd54) st_q <= S_A;
				S_A: st_q <= S_A2;
				S_A2: st_q <= S_T1;
				S_T1: st_q <= S_T2;
				S_T2: st_q <= S_NV;
				S_NV: st_q <= S_ACC;
				S_ACC: if (!out_v_q) begin
					out_v_q <= 1'b1;
					acc_q <= w_q.last ? '0 : accn;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				w_q <= wk;
				rem_q <= 49'h1_0000_0000 + 49'(wk.um) * 49'(wk.um);
				res_q <= '0;
				bit_q <= 50'd1 << 48;
			end
			S_SQRT: begin
				if (bit_q != '0) begin
					if ({1'b0, rem_q} >= rb) begin
						rem_q <= 49'({1'b0, rem_q} - rb);
						res_q <= 49'((res_q >> 1) + 49'(bit_q));
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					dnum_q <= {1'b0, w_q.um, 30'd0};
					drem_q <= '0;
					cnt_q <= '0;
				end
			end
			S_DIV: begin
				cnt_q <= cnt_q + 6'd1;
				dnum_q <= {dnum_q[53:0], ~dtrial[34]};
				drem_q <= dtrial[34] ? {drem_q[33:0], dnum_q[54]} : dtrial;
			end
			S_A: begin
				rm_q <= dnum_q[30:0];
				am_q <= 31'(({16'd0, dnum_q[30:0]} * {31'd0, step_ratio}) >> 16);
				dlr_q <= 34'(w_q.vl) - 34'(w_q.vr);
				d2_q <= 35'(w_q.vc) * 35'sd2 - 35'(w_q.vl) - 35'(w_q.vr);
			end
			S_A2: a2_q <= 31'(({31'd0, am_q} * {31'd0, am_q}) >> rlwa_pkg::VEL_REL_FRAC);
			S_T1: t1_q <= (w_q.neg != dlr_q[33]) ? -$signed({32'd0, p1[62:31]})
				: $signed({32'd0, p1[62:31]});
			S_T2: t2_q <= d2_q[34] ? -$signed({32'd0, p2[62:31]}) : $signed({32'd0, p2[62:31]});
			S_NV: nv_q <= (nvw > 66'sd2147483647) ? 32'sh7fffffff
				: (nvw < -66'sd2147483648) ? 32'sh80000000 : nvw[31:0];
			S_ACC: if (!out_v_q) begin
				ob_q.new_value <= nv_q;
				ob_q.moment_sum <= w_q.last ? accn : '0;
				ob_q.sum_valid <= w_q.last;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/relativistic_lax_wendroff_advect_unit.sv =====
// top level of the relativistic lax-wendroff advection unit
// path from input beat to output valid: dequeue, sqrt, divide, then the a, a2, t1, t2, nv and acc states
// the back end takes no new beat until it is through with the last one
// a held output beat stalls the back end; the two-entry queue lets the front accept meanwhile
// arst_n clears control, the accumulator and sets step_ratio to 0.5
`default_nettype none
module relativistic_lax_wendroff_advect_unit (
	input wire logic clk,
	input wire logic arst_n,
	rlwa_stream_if.sink in_s,
	rlwa_stream_if.source out_s,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [15:0] step_ratio_q;
	rlwa_pkg::work_t wk;
	logic wk_valid, wk_ready;
	logic sel0;

	assign pready = 1'b1;
	assign sel0 = (paddr[2] == rlwa_pkg::REG_STEP_RATIO) && (paddr[1:0] == 2'b00);
	assign prdata = sel0 ? {16'd0, step_ratio_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_ratio_q <= rlwa_pkg::STEP_RATIO_RESET;
		else if (psel && penable && pwrite && sel0) step_ratio_q <= pwdata[15:0];
	end

	rlwa_front u_front (.clk, .arst_n, .in_s, .wk, .wk_valid, .wk_ready);
	rlwa_back u_back (.clk, .arst_n, .wk, .wk_valid, .wk_ready,
		.step_ratio(step_ratio_q), .out_s);
endmodule
`default_nettype wire

// ===== tb/tb_rlwa_checker.sv =====
// checker: predicts advected values and moment sums and compares output beats
`timescale 1ns / 100ps
module tb_rlwa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [$bits(rlwa_pkg::in_beat_t)-1:0] in_data,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [$bits(rlwa_pkg::out_beat_t)-1:0] out_data,
	input wire logic cfg_wr,
	input wire logic [2:0] cfg_addr,
	input wire logic [31:0] cfg_wdata,
	output int err_count,
	output int pending
);
	logic [15:0] ratio;
	logic signed [63:0] moment_acc;
	rlwa_pkg::out_beat_t advect_q[$];

	assign pending = advect_q.size();

	function automatic logic [63:0] root64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic signed [63:0] mulsh(input logic signed [63:0] x,
			input logic signed [63:0] y, input int sh);
		logic [63:0] mx;
		logic [63:0] my;
		logic [63:0] p;
		mx = x < 0 ? -x : x;
		my = y < 0 ? -y : y;
		p = (mx * my) >> sh;
		return ((x < 0) != (y < 0)) ? -$signed(p) : $signed(p);
	endfunction

	task automatic predict_advect(input rlwa_pkg::in_beat_t b);
		logic signed [63:0] u, vl, vc, vr, r, a, a2, t1, t2, nv, ctr, sum;
		logic [63:0] um, s, rm;
		rlwa_pkg::out_beat_t o;
		u = b.slice_velocity;
		vl = b.value_left;
		vc = b.value_center;
		vr = b.value_right;
		um = u < 0 ? -u : u;
		s = root64((64'd1 << 32) + um * um);
		rm = (um << rlwa_pkg::VEL_REL_FRAC) / s;
		r = u < 0 ? -$signed(rm) : $signed(rm);
		a = mulsh(r, {48'd0, ratio}, 16);
		a2 = mulsh(a, a, rlwa_pkg::VEL_REL_FRAC);
		t1 = mulsh(a, vl - vr, rlwa_pkg::VEL_REL_FRAC + 1);
		t2 = mulsh(a2, 2 * vc - vl - vr, rlwa_pkg::VEL_REL_FRAC + 1);
		nv = vc + t1 - t2;
		if (nv > 64'sd2147483647) nv = 64'sd2147483647;
		if (nv < -64'sd2147483648) nv = -64'sd2147483648;
		ctr = mulsh(r, nv, rlwa_pkg::MOMENT_SHIFT);
		sum = moment_acc + ctr;
		if (ctr > 0 && moment_acc > 0 && sum < 0) sum = {1'b0, {63{1'b1}}};
		if (ctr < 0 && moment_acc < 0 && sum >= 0) sum = {1'b1, 63'd0};
		o.new_value = nv[31:0];
		if (b.last_item) begin
			o.moment_sum = sum;
			o.sum_valid = 1'b1;
			moment_acc = 0;
		end else begin
			o.moment_sum = 0;
			o.sum_valid = 1'b0;
			moment_acc = sum;
		end
		advect_q.push_back(o);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio <= rlwa_pkg::STEP_RATIO_RESET;
			moment_acc <= 0;
			err_count <= 0;
			advect_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				rlwa_pkg::out_beat_t g, e;
				g = out_data;
				if (advect_q.size() == 0) begin
					report("unexpected beat", g.new_value, 0);
				end else begin
					e = advect_q.pop_front();
					if (g.new_value !== e.new_value) report("new_value", g.new_value, e.new_value);
					if (g.moment_sum !== e.moment_sum) report("moment_sum", g.moment_sum, e.moment_sum);
					if (g.sum_valid !== e.sum_valid) report("sum_valid", g.sum_valid, e.sum_valid);
				end
			end
			if (in_valid && in_ready) predict_advect(in_data);
			if (cfg_wr && cfg_addr[2:2] == rlwa_pkg::REG_STEP_RATIO && cfg_addr[1:0] == 2'd0)
				ratio <= cfg_wdata[15:0];
		end
	end
endmodule

// ===== tb/tb_relativistic_lax_wendroff_advect_unit.sv =====
// testbench top: drives advection beats and step_ratio writes, gives the verdict
`timescale 1ns / 100ps
module tb_relativistic_lax_wendroff_advect_unit;
	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	int err_count, pending;
	int cycles;
	bit calm;

	rlwa_stream_if #($bits(rlwa_pkg::in_beat_t)) in_s();
	rlwa_stream_if #($bits(rlwa_pkg::out_beat_t)) out_s();

	relativistic_lax_wendroff_advect_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_s(in_s.sink), .out_s(out_s.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tb_rlwa_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_s.valid), .in_ready(in_s.ready), .in_data(in_s.data),
		.out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data),
		.cfg_wr(psel && penable && pwrite && pready), .cfg_addr(paddr), .cfg_wdata(pwdata),
		.err_count(err_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		out_s.ready <= calm || ($urandom_range(99) >= 20);
		if (cycles > 600000) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] d);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= d;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		@(posedge clk);
	endtask

	task automatic drain;
		in_s.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic send_beat(input rlwa_pkg::in_beat_t b);
		if (!calm && $urandom_range(99) < 20) begin
			in_s.valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < 20) @(posedge clk);
		end
		in_s.valid <= 1;
		in_s.data <= b;
		@(posedge clk);
		while (!in_s.ready) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	function automatic rlwa_pkg::in_beat_t rand_beat(input int run_len);
		rlwa_pkg::in_beat_t b;
		case ($urandom_range(4))
			0: b.slice_velocity = 24'h7fffff;
			1: b.slice_velocity = 24'h800000;
			2: b.slice_velocity = 24'($urandom_range(1048576) - 524288);
			default: b.slice_velocity = 24'($urandom);
		endcase
		b.value_left = pick_value();
		b.value_center = pick_value();
		b.value_right = pick_value();
		b.last_item = ($urandom_range(run_len) == 0);
		return b;
	endfunction

	function automatic rlwa_pkg::in_beat_t mk(input logic [23:0] v, input logic [31:0] l,
			input logic [31:0] c, input logic [31:0] r, input logic e);
		rlwa_pkg::in_beat_t b;
		b.slice_velocity = v; b.value_left = l; b.value_center = c;
		b.value_right = r; b.last_item = e;
		return b;
	endfunction

	logic [15:0] ratios[5] = '{16'd0, 16'hffff, 16'd1, 16'd32768, 16'd49152};

	initial begin
		arst_n = 0;
		calm = 0;
		cycles = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_s.valid = 0; in_s.data = 0; out_s.ready = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_beat(mk(24'h010000, 32'h00010000, 32'h00020000, 32'h00030000, 1'b0));
		send_beat(mk(24'h7fffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0));
		send_beat(mk(24'h800000, 32'h7fffffff, 32'h80000000, 32'h80000000, 1'b0));
		send_beat(mk(24'h000000, 32'hffffffff, 32'h12345678, 32'h00000001, 1'b1));
		send_beat(mk(24'hffffff, 32'h00000000, 32'hffffffff, 32'h00000000, 1'b1));
		drain();
		reg_write(3'd4, 32'h0000_1234);
		reg_write(3'd0, 32'hffff_ffff);
		for (int k = 0; k < 12; k++)
			send_beat(mk(k[0] ? 24'h7fffff : 24'h800000, 32'h7fffffff,
				32'h7fffffff, 32'h80000000, k == 11));
		for (int k = 0; k < 6; k++)
			send_beat(mk(24'h7fffff, 32'h80000000, 32'h80000000, 32'h7fffffff, k == 5));
		drain();
		for (int p = 0; p < 5; p++) begin
			reg_write(3'd0, {16'($urandom_range(65535)), ratios[p]});
			calm = (p == 2);
			for (int i = 0; i < 190; i++) send_beat(rand_beat(p == 1 ? 1 : 20));
			drain();
		end
		calm = 0;
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/rlwa_pkg.sv
src/rlwa_stream_if.sv
src/rlwa_front.sv
src/rlwa_back.sv
src/relativistic_lax_wendroff_advect_unit.sv
tb/tb_rlwa_checker.sv
tb/tb_relativistic_lax_wendroff_advect_unit.sv
